FILE: src/color_mask_threshold_dilate_defines.svh
// assertion macros for the color mask threshold dilate block
`ifndef COLOR_MASK_THRESHOLD_DILATE_DEFINES_SVH
`define COLOR_MASK_THRESHOLD_DILATE_DEFINES_SVH

// same-cycle implication, checked on clk, disabled while rst_n is low
`define CMTD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, disabled while rst_n is low
`define CMTD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cmtd_pkg.sv
// shared types and constants for the color mask threshold dilate block
package cmtd_pkg;

  // counter and register widths
  localparam int CNT_W       = 12;
  localparam int CHAN_W      = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int STORE_W     = 2;
  localparam int WIN_W       = 9;

  // default line store depth
  localparam int MAX_WIDTH_DEF = 2048;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEAM_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PURITY_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  // reset values of the configuration registers
  localparam logic              RST_TEAM_COLOR   = 1'b0;
  localparam logic [CHAN_W-1:0] RST_COLOR_THR    = 8'd40;
  localparam logic [CHAN_W-1:0] RST_PURITY_THR   = 8'd20;
  localparam logic [CHAN_W-1:0] RST_BRIGHT_THR   = 8'd80;
  localparam logic [CNT_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CNT_W-1:0]  RST_FRAME_HEIGHT = 12'd480;

  // team color codes
  localparam logic TEAM_BLUE = 1'b1;

  // item opcode: drain tick
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } in_beat_t;

  typedef struct packed {
    logic mask;
    logic frame_last;
  } out_beat_t;

  // per-item control carried from the input stage to the window stage
  typedef struct packed {
    logic mark;
    logic has_out;
    logic use_top;
    logic use_bot;
    logic use_left;
    logic use_right;
    logic last;
  } stage_flags_t;

endpackage

FILE: src/color_mask_threshold_dilate.sv
// Team-color mask with plus-shaped 3x3 dilation over a raster pixel stream.
// One beat is taken every clock when the result side keeps up; a pixel's
// result leaves one row plus one pixel later in the stream, and after the
// last pixel of a frame, frame_width plus one drain beats flush the tail,
// the last one flagged with frame_last. Inside the block the input stage
// classifies the pixel, steps the raster counters and reads the two-row line
// store; the window stage updates the 3x3 window, writes the line store back
// and loads the output register. The rate of one beat per clock is set by
// the line store, one read and one write per clock on a single two-bit-wide
// ram of MAX_WIDTH entries. The line store is not cleared after reset; rows
// above the frame are masked, so no clearing pass is needed. Configuration
// is written through cfg_we, cfg_index and cfg_data; the user must do so
// only while no beat is in flight, and the block does not enforce it.
module color_mask_threshold_dilate #(
  parameter int MAX_WIDTH = cmtd_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cmtd_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cmtd_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [cmtd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cmtd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cmtd_pkg::*;

`include "color_mask_threshold_dilate_defines.svh"

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int MW_W  = $clog2(MAX_WIDTH + 1);
  localparam int WW    = (MW_W > CNT_W) ? MW_W : CNT_W;

  // configuration registers
  logic              cfg_team_r;
  logic [CHAN_W-1:0] cfg_cthr_r;
  logic [CHAN_W-1:0] cfg_pthr_r;
  logic [CHAN_W-1:0] cfg_bthr_r;
  logic [CNT_W-1:0]  cfg_width_r;
  logic [CNT_W-1:0]  cfg_height_r;

  // raster counters
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [CNT_W-1:0] drain_cnt_r, drain_cnt_nxt;

  // window stage
  logic         s1_valid_r;
  logic [AW-1:0] s1_addr_r;
  stage_flags_t s1_flags_r;
  logic [WIN_W-1:0] window_r;
  logic [WIN_W-1:0] window_nxt;

  // write bypass for a read that meets a write at the same edge
  logic          byp_valid_r;
  logic [AW-1:0] byp_addr_r;
  logic [STORE_W-1:0] byp_data_r;

  // output register
  logic      out_valid_r;
  out_beat_t out_data_r;

  logic              in_take;
  logic              s1_adv;
  logic              s0_load;
  logic [AW-1:0]     s0_addr;
  stage_flags_t      s0_flags;
  logic [WW-1:0]     w_eff;
  logic [CNT_W-1:0]  h_eff;
  logic [CNT_W-1:0]  col1;
  logic [CNT_W-1:0]  row1;
  logic [WW-1:0]     col_inc;
  logic              pix_phase;
  logic              pix_mark;
  logic [STORE_W-1:0] ram_rdata;
  logic [STORE_W-1:0] old_bits;
  logic [2:0]        new_col;
  logic              res_mask;

  // test one pixel against the three thresholds
  function automatic logic mark_of(
    input logic              team,
    input logic [CHAN_W-1:0] b,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] r,
    input logic [CHAN_W-1:0] cthr,
    input logic [CHAN_W-1:0] pthr,
    input logic [CHAN_W-1:0] bthr
  );
    logic [CHAN_W-1:0] t;
    logic [CHAN_W-1:0] o;
    logic              pass_c;
    logic              pass_p;
    t      = (team == TEAM_BLUE) ? b : r;
    o      = (team == TEAM_BLUE) ? r : b;
    pass_c = (t > o) && ((t - o) > cthr);
    pass_p = (t > g) && ((t - g) > pthr);
    return pass_c && pass_p && (t > bthr);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_team_r   <= RST_TEAM_COLOR;
      cfg_cthr_r   <= RST_COLOR_THR;
      cfg_pthr_r   <= RST_PURITY_THR;
      cfg_bthr_r   <= RST_BRIGHT_THR;
      cfg_width_r  <= RST_FRAME_WIDTH;
      cfg_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEAM_COLOR:   cfg_team_r   <= cfg_data[0];
        REG_COLOR_THR:    cfg_cthr_r   <= cfg_data[CHAN_W-1:0];
        REG_PURITY_THR:   cfg_pthr_r   <= cfg_data[CHAN_W-1:0];
        REG_BRIGHT_THR:   cfg_bthr_r   <= cfg_data[CHAN_W-1:0];
        REG_FRAME_WIDTH:  cfg_width_r  <= cfg_data[CNT_W-1:0];
        REG_FRAME_HEIGHT: cfg_height_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size: a zero size taken as one, width clamped to the line store
  always_comb begin
    w_eff = WW'(cfg_width_r);
    if (cfg_width_r == '0) begin
      w_eff = WW'(1);
    end else if (WW'(cfg_width_r) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = (cfg_height_r == '0) ? CNT_W'(1) : cfg_height_r;
  end

  // handshake
  assign s1_adv   = s1_valid_r && (!s1_flags_r.has_out || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign pix_mark = mark_of(cfg_team_r, in_data.blue, in_data.green, in_data.red,
                            cfg_cthr_r, cfg_pthr_r, cfg_bthr_r);

  // input stage: raster position, window flags and line store address
  always_comb begin
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    s0_load       = 1'b0;
    s0_addr       = '0;
    s0_flags      = '0;

    // wrap a column left beyond the width by a width change
    if (WW'(col_cnt_r) >= w_eff) begin
      col1 = '0;
      row1 = row_cnt_r + CNT_W'(1);
    end else begin
      col1 = col_cnt_r;
      row1 = row_cnt_r;
    end
    pix_phase = row1 < h_eff;
    col_inc   = WW'(col1) + WW'(1);

    if (in_take) begin
      col_cnt_nxt = col1;
      row_cnt_nxt = row1;
      if (pix_phase && in_data.op == OP_DRAIN) begin
        // early drain: nothing but the wrap
      end else if (pix_phase) begin
        s0_load       = 1'b1;
        s0_addr       = AW'(col1);
        s0_flags.mark = pix_mark;
        if (col1 != '0) begin
          s0_flags.has_out   = row1 >= CNT_W'(1);
          s0_flags.use_top   = row1 >= CNT_W'(2);
          s0_flags.use_bot   = 1'b1;
          s0_flags.use_left  = col1 >= CNT_W'(2);
          s0_flags.use_right = 1'b1;
        end else begin
          // first column: result is the last pixel two rows up
          s0_flags.has_out   = row1 >= CNT_W'(2);
          s0_flags.use_top   = row1 >= CNT_W'(3);
          s0_flags.use_bot   = 1'b1;
          s0_flags.use_left  = w_eff >= WW'(2);
          s0_flags.use_right = 1'b0;
        end
        if (col_inc >= w_eff) begin
          col_cnt_nxt = '0;
          row_cnt_nxt = row1 + CNT_W'(1);
        end else begin
          col_cnt_nxt = CNT_W'(col_inc);
        end
      end else begin
        // drain beat, also for a pixel past the frame
        s0_load       = 1'b1;
        drain_cnt_nxt = drain_cnt_r + CNT_W'(1);
        if (WW'(drain_cnt_r) >= w_eff) begin
          s0_addr            = '0;
          s0_flags.has_out   = 1'b1;
          s0_flags.use_top   = h_eff >= CNT_W'(2);
          s0_flags.use_left  = w_eff >= WW'(2);
          s0_flags.last      = 1'b1;
          col_cnt_nxt        = '0;
          row_cnt_nxt        = '0;
          drain_cnt_nxt      = '0;
        end else if (drain_cnt_r != '0) begin
          s0_addr            = AW'(drain_cnt_r);
          s0_flags.has_out   = 1'b1;
          s0_flags.use_top   = h_eff >= CNT_W'(2);
          s0_flags.use_left  = drain_cnt_r >= CNT_W'(2);
          s0_flags.use_right = 1'b1;
        end else begin
          s0_addr            = '0;
          s0_flags.has_out   = h_eff >= CNT_W'(2);
          s0_flags.use_top   = h_eff >= CNT_W'(3);
          s0_flags.use_bot   = 1'b1;
          s0_flags.use_left  = w_eff >= WW'(2);
        end
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      drain_cnt_r <= '0;
    end else begin
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  // two-row line store: bit 1 is the row above, bit 0 two rows above
  cmtd_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata ({s1_flags_r.mark, old_bits[1]}),
    .re    (s0_load),
    .raddr (s0_addr),
    .rdata (ram_rdata)
  );

  // window stage: new column, dilation of the center pixel
  always_comb begin
    old_bits = (byp_valid_r && byp_addr_r == s1_addr_r) ? byp_data_r : ram_rdata;
    new_col  = {s1_flags_r.mark, old_bits[1], old_bits[0]};
    window_nxt = {new_col, window_r[WIN_W-1:3]};
    res_mask = window_nxt[4]
             | (s1_flags_r.use_top   & window_nxt[3])
             | (s1_flags_r.use_bot   & window_nxt[5])
             | (s1_flags_r.use_left  & window_nxt[1])
             | (s1_flags_r.use_right & window_nxt[7]);
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      window_r    <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= s0_load;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        window_r    <= s1_flags_r.last ? '0 : window_nxt;
        byp_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && s0_load) begin
      s1_addr_r  <= s0_addr;
      s1_flags_r <= s0_flags;
    end
    if (s1_adv) begin
      byp_addr_r <= s1_addr_r;
      byp_data_r <= {s1_flags_r.mark, old_bits[1]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_flags_r.has_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags_r.has_out) begin
      out_data_r.mask       <= res_mask;
      out_data_r.frame_last <= s1_flags_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `CMTD_ASSERT_IMP(a_stall_needs_stage, in_stall, s1_valid_r && s1_flags_r.has_out, "input stall without a pending result")
  `CMTD_ASSERT_NXT(a_last_clears_counters, in_take && s0_flags.last, (col_cnt_r == '0) && (row_cnt_r == '0) && (drain_cnt_r == '0), "frame end left counters set")
  `CMTD_ASSERT_NXT(a_last_clears_window, s1_adv && s1_flags_r.last, window_r == '0, "frame end left window bits set")
  `CMTD_ASSERT_NXT(a_stage_holds, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_addr_r) && $stable(s1_flags_r), "stalled stage changed")

endmodule

FILE: src/cmtd_ram.sv
// generic single write port, single read port ram with registered read
module cmtd_ram #(
  parameter int WIDTH = cmtd_pkg::STORE_W,
  parameter int DEPTH = cmtd_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the team color mask with cross dilation
`timescale 1ns / 100ps

module testbench;
  import cmtd_pkg::*;

  localparam int QUIET_LIMIT   = 2000;  // cycles with no beat moving before giving up
  localparam int HOLD_CYCLES   = 200;   // long result hold-off
  localparam int SETTLE_CYCLES = 8;     // two-stage pipe plus margin
  localparam int RANDOM_BEATS  = 780;

  // expected mask results, kept by mirroring the raster window of the block
  class mask_tracker;
    bit         team;
    int         color_thr, purity_thr, bright_thr;
    int         width_reg, height_reg;
    bit         upper_row [MAX_WIDTH_DEF];
    bit         mid_row [MAX_WIDTH_DEF];
    bit [WIN_W-1:0] win;
    int         col, row, drains;
    out_beat_t  mask_due[$];
    int         n_checked, n_errors, n_frames, n_pixels;

    function new();
      team       = RST_TEAM_COLOR;
      color_thr  = int'(RST_COLOR_THR);
      purity_thr = int'(RST_PURITY_THR);
      bright_thr = int'(RST_BRIGHT_THR);
      width_reg  = int'(RST_FRAME_WIDTH);
      height_reg = int'(RST_FRAME_HEIGHT);
      win        = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TEAM_COLOR:   team = data[0];
        REG_COLOR_THR:    color_thr = int'(data[CHAN_W-1:0]);
        REG_PURITY_THR:   purity_thr = int'(data[CHAN_W-1:0]);
        REG_BRIGHT_THR:   bright_thr = int'(data[CHAN_W-1:0]);
        REG_FRAME_WIDTH:  width_reg = int'(data);
        REG_FRAME_HEIGHT: height_reg = int'(data);
        default: ;
      endcase
    endfunction

    function int eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int eff_height();
      return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function bit exceeds(int t, int o, int thr);
      return t > o && (t - o) > thr;
    endfunction

    // one accepted input beat: step the raster and queue the result it releases
    function void take_in(in_beat_t b);
      int w, h, c, pr, pc, t, o;
      bit m, last;
      bit [2:0] stack;
      out_beat_t res;
      w = eff_width();
      h = eff_height();
      m = 1'b0;
      last = 1'b0;
      if (col >= w) begin
        col = 0;
        row = (row + 1) & 'hFFF;
      end
      if (row < h) begin
        // drains are ignored while pixels are still due
        if (b.op == OP_DRAIN) return;
        c = col;
        t = (team == TEAM_BLUE) ? int'(b.blue) : int'(b.red);
        o = (team == TEAM_BLUE) ? int'(b.red) : int'(b.blue);
        m = exceeds(t, o, color_thr) && exceeds(t, int'(b.green), purity_thr) &&
            t > bright_thr;
        n_pixels++;
        if (c >= 1) begin
          pr = row - 1;
          pc = c - 1;
        end else begin
          pr = row - 2;
          pc = w - 1;
        end
        col++;
        if (col >= w) begin
          col = 0;
          row = (row + 1) & 'hFFF;
        end
      end else begin
        // frame tail, any beat counts as a drain
        if (drains >= w) begin
          last = 1'b1;
          c = 0;
          pr = h - 1;
          pc = w - 1;
        end else if (drains >= 1) begin
          c = drains;
          pr = h - 1;
          pc = drains - 1;
        end else begin
          c = 0;
          pr = h - 2;
          pc = w - 1;
        end
        drains = (drains + 1) & 'hFFF;
      end
      if (c >= MAX_WIDTH_DEF) c = 0;
      // shift a new column into the window and roll the line stores
      stack = {m, mid_row[c], upper_row[c]};
      win = {stack, win[WIN_W-1:3]};
      upper_row[c] = mid_row[c];
      mid_row[c] = m;
      if (last) begin
        col = 0;
        row = 0;
        drains = 0;
        n_frames++;
      end
      if (pr < 0) return;
      // cross dilation, neighbors outside the frame masked
      res.mask = win[4] | ((pr >= 1) & win[3]) | ((pr + 1 < h) & win[5]) |
                 ((pc >= 1) & win[1]) | ((pc + 1 < w) & win[7]);
      res.frame_last = last;
      if (last) win = '0;
      mask_due.push_back(res);
    endfunction

    function void check_out(out_beat_t got);
      out_beat_t want;
      if (mask_due.size() == 0) begin
        $display("%0t: unexpected result beat, actual mask=%0b frame_last=%0b",
                 $time, got.mask, got.frame_last);
        n_errors++;
        return;
      end
      want = mask_due.pop_front();
      n_checked++;
      if (got.mask !== want.mask) begin
        $display("%0t: mask expected %0b actual %0b", $time, want.mask, got.mask);
        n_errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last expected %0b actual %0b",
                 $time, want.frame_last, got.frame_last);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mask_tracker sb;
  int  in_gap_mode = 1;
  int  stall_mode = 1;
  bit  hold_req = 1'b0;
  int  frame_beats = 0;
  int  n_phases = 0;

  color_mask_threshold_dilate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random idle length: mode 0 never idles, else mostly short with a few long
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_beat_t rgb(int r, int g, int b);
    in_beat_t p;
    p.op = 1'b0;
    p.red = CHAN_W'(r);
    p.green = CHAN_W'(g);
    p.blue = CHAN_W'(b);
    return p;
  endfunction

  // half fully random, half leaning toward the team color
  function automatic in_beat_t any_pixel();
    int hi, opp;
    if ($urandom_range(0, 1)) return rgb($urandom, $urandom, $urandom);
    hi = $urandom_range(100, 255);
    opp = $urandom_range(0, 120);
    if (sb.team == TEAM_BLUE) return rgb(opp, $urandom_range(0, 120), hi);
    return rgb(hi, $urandom_range(0, 120), opp);
  endfunction

  function automatic int pick_thr();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(0, 120);
  endfunction

  function automatic int pick_size(int hi);
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, hi);
  endfunction

  // input beats: called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_drain();
    in_beat_t d;
    d = rgb($urandom, $urandom, $urandom);
    d.op = OP_DRAIN;
    send_beat(d);
  endtask

  // tail of a frame: drains, sometimes a stray pixel, until frame_last is due
  task automatic flush_frame();
    int done_before, n;
    done_before = sb.n_frames;
    n = 0;
    while (sb.n_frames == done_before && n < 4200) begin
      if ($urandom_range(0, 9) == 0) send_beat(any_pixel());
      else send_drain();
      frame_beats++;
      n++;
    end
  endtask

  task automatic run_frame(input bit noise, input int hold_at);
    int total;
    total = sb.eff_width() * sb.eff_height();
    for (int i = 0; i < total; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      // early drains are dropped by the block
      if (noise && $urandom_range(0, 19) == 0) send_drain();
      send_beat(any_pixel());
      frame_beats++;
    end
    flush_frame();
  endtask

  // idle: every expected beat returned and the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.mask_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    sb.set_reg(idx, value[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int tc, input int cthr, input int pthr, input int bthr,
                           input int w, input int h);
    cfg_write(REG_TEAM_COLOR, tc);
    cfg_write(REG_COLOR_THR, cthr);
    cfg_write(REG_PURITY_THR, pthr);
    cfg_write(REG_BRIGHT_THR, bthr);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    n_phases++;
  endtask

  // monitor: note inputs, check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_in(in_data);
      if (out_valid && !out_stall) sb.check_out(out_data);
    end
  end

  // result side stalls, plus the long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        n = pick_gap(stall_mode);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  // watchdog on cycles where no beat moves
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: threshold edges on a 3x3 red frame
    configure(0, 40, 20, 80, 3, 3);
    send_drain();
    send_beat(rgb(255, 0, 0));
    send_beat(rgb(0, 0, 0));
    send_beat(rgb(255, 255, 255));
    send_beat(rgb(121, 100, 80));
    send_drain();
    send_beat(rgb(120, 99, 80));
    send_beat(rgb(121, 101, 0));
    send_beat(rgb(81, 60, 0));
    send_beat(rgb(80, 0, 0));
    send_beat(rgb(10, 0, 200));
    send_drain();
    send_beat(rgb(255, 0, 0));
    send_drain();
    send_drain();
    send_drain();
    settle();

    // directed: blue target, zero thresholds, size changes inside a frame
    configure(int'(TEAM_BLUE), 0, 0, 0, 2048, 2);
    send_beat(rgb(0, 0, 1));
    send_beat(rgb(1, 0, 1));
    send_beat(rgb(0, 255, 255));
    send_beat(rgb(254, 254, 255));
    send_beat(rgb(0, 0, 0));
    settle();
    cfg_write(REG_FRAME_WIDTH, 3);
    send_beat(rgb(0, 0, 255));
    send_beat(rgb(255, 255, 0));
    send_beat(rgb(0, 0, 255));
    send_drain();
    send_drain();
    settle();
    cfg_write(REG_FRAME_WIDTH, 1);
    flush_frame();
    settle();

    // random frames, mostly small
    frame_beats = 0;
    while (frame_beats < RANDOM_BEATS) begin
      configure($urandom_range(0, 1), pick_thr(), pick_thr(), pick_thr(),
                pick_size(12), pick_size(6));
      in_gap_mode = $urandom_range(0, 3);
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 3)) run_frame(1'b1, -1);
      settle();
    end

    // back pressure: long result hold-off while pixels keep coming
    configure($urandom_range(0, 1), 30, 15, 60, 10, 30);
    in_gap_mode = 0;
    stall_mode = 0;
    run_frame(1'b0, 40);
    settle();

    // tallest frame register, cut short by a height change
    stall_mode = 1;
    configure($urandom_range(0, 1), 40, 20, 80, 2, 4095);
    repeat (7) send_beat(any_pixel());
    settle();
    cfg_write(REG_FRAME_HEIGHT, 2);
    flush_frame();
    settle();

    // oversized width register clamped to the line store, then narrowed mid-row
    configure($urandom_range(0, 1), 40, 20, 80, 4095, 3);
    repeat (6) send_beat(any_pixel());
    settle();
    cfg_write(REG_FRAME_WIDTH, 3);
    repeat (6) send_beat(any_pixel());
    flush_frame();
    settle();
    repeat (20) @(posedge clk);

    $display("covered %0d frames in %0d settings, %0d pixels, %0d result beats checked",
             sb.n_frames, n_phases, sb.n_pixels, sb.n_checked);
    $display("including clamped sizes, size changes mid-frame and a long result hold-off");
    if (sb.n_errors == 0 && sb.mask_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/cmtd_pkg.sv
src/cmtd_ram.sv
src/color_mask_threshold_dilate.sv
sim/testbench.sv
